>>> hdl/gna_pkg.sv
`timescale 1ns / 1ps
// gna_pkg: beat types, field widths and codes for the greedy nearest association block.
// No dependencies.
package gna_pkg;

    localparam int COORD_W  = 16;
    localparam int SIZE_W   = 15;
    localparam int SCORE_W  = 16;
    localparam int CTR_W    = 18;   // doubled centre, signed
    localparam int DIFF_W   = 19;   // centre minus doubled position, signed
    localparam int OPND_W   = 18;   // multiplier operand, unsigned
    localparam int PROD_W   = 2 * OPND_W;
    localparam int SUM_W    = PROD_W + 1;
    localparam int GAIN_FRAC = 14;
    localparam int SLOT_OUT_W = 6;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_CAMERA = 2'd1;
    localparam logic [1:0] KIND_LIDAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_MATCH_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LIDAR_GAIN   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAMERA_GAIN  = 2'd2;

    localparam logic [CFG_W-1:0] RST_MATCH_RADIUS = 16'd64;
    localparam logic [CFG_W-1:0] RST_LIDAR_GAIN   = 16'd11469;
    localparam logic [CFG_W-1:0] RST_CAMERA_GAIN  = 16'd4915;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic [SIZE_W-1:0]         box_wide;
        logic [SIZE_W-1:0]         box_tall;
        logic [SCORE_W-1:0]        box_score;
        logic signed [COORD_W-1:0] obj_px;
        logic signed [COORD_W-1:0] obj_py;
        logic [SCORE_W-1:0]        obj_score;
    } t_in;

    typedef struct packed {
        logic                  matched;
        logic [SLOT_OUT_W-1:0] match_slot;
        logic [SCORE_W-1:0]    fused_score;
    } t_out;

    typedef struct packed {
        logic signed [CTR_W-1:0] x2;
        logic signed [CTR_W-1:0] y2;
        logic [SCORE_W-1:0]      score;
    } t_slot;

endpackage

>>> hdl/gna_mac.sv
`timescale 1ns / 1ps
// gna_mac: shared two-product multiply-add unit, a0*b0 + a1*b1, two register stages.
// Depends on gna_pkg.
module gna_mac
    import gna_pkg::*;
(
    input  logic              i_clk,
    input  logic [OPND_W-1:0] i_a0,
    input  logic [OPND_W-1:0] i_b0,
    input  logic [OPND_W-1:0] i_a1,
    input  logic [OPND_W-1:0] i_b1,
    output logic [SUM_W-1:0]  o_sum
);

    logic [PROD_W-1:0] r_p0;
    logic [PROD_W-1:0] r_p1;
    logic [SUM_W-1:0]  r_sum;

    always_ff @(posedge i_clk) begin
        r_p0  <= i_a0 * i_b0;
        r_p1  <= i_a1 * i_b1;
        r_sum <= {1'b0, r_p0} + {1'b0, r_p1};
    end

    assign o_sum = r_sum;

endmodule

>>> hdl/gna_table.sv
`timescale 1ns / 1ps
// gna_table: frame table of detection centres/scores plus the taken flags.
// Registered read at one address per cycle. Depends on gna_pkg.
module gna_table
    import gna_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int IDX_W = 6
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  t_slot            i_wr_data,
    input  logic             i_tk_we,
    input  logic [IDX_W-1:0] i_tk_addr,
    input  logic             i_tk_val,
    input  logic [IDX_W-1:0] i_rd_addr,
    output t_slot            o_rd_data,
    output logic             o_rd_taken
);

    t_slot r_mem   [DEPTH];
    logic  r_taken [DEPTH];
    t_slot r_rd_data;
    logic  r_rd_taken;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_tk_we) begin
            r_taken[i_tk_addr] <= i_tk_val;
        end
        r_rd_taken <= r_taken[i_rd_addr];
    end

    assign o_rd_data  = r_rd_data;
    assign o_rd_taken = r_rd_taken;

endmodule

>>> hdl/greedy_nearest_association.sv
`timescale 1ns / 1ps
// greedy_nearest_association: top level, sequencer around the frame table and shared MAC.
// Depends on gna_pkg, gna_table, gna_mac.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+------------------
//   in       | i_in_valid / o_in_ready   | i_in_data  (t_in)
//   out      | o_out_valid / i_out_ready | o_out_data (t_out)
//   cfg      | i_cfg_we                  | i_cfg_idx, i_cfg_data
//
// Clear, camera and ignored beats are taken in the idle state and leave the block idle.
// A lidar beat reads the stored detections from the table one slot per cycle, and each
// distance goes through the shared MAC (two stages); on a match the blend and sum states
// follow, then saturate and done, where it waits for the out slot before returning to idle.
// Reset is synchronous and clears the count, sequencer and output valid.
// A pending result does not stall input; only a finished lidar beat waits for the out slot.
module greedy_nearest_association
    import gna_pkg::*;
#(
    parameter int MAX_DETECTIONS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in                  i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out                 o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int IDX_W = (MAX_DETECTIONS > 1) ? $clog2(MAX_DETECTIONS) : 1;
    localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_DETECTIONS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_BLEND, ST_BSUM, ST_SAT, ST_DONE
    } t_state;

    t_state n_state;
    t_state r_state;

    logic [CFG_W-1:0] r_radius;
    logic [CFG_W-1:0] r_lgain;
    logic [CFG_W-1:0] r_cgain;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_addr;
    t_in              r_item;

    // scan pipeline: s0 table out, s1 abs values, s2 products, s3 sum
    logic             r_v0, r_v1, r_v2, r_v3;
    logic             r_thr1, r_thr2, r_thr3;
    logic             r_tk1, r_tk2, r_tk3;
    logic [IDX_W-1:0] r_i0, r_i1, r_i2, r_i3;
    logic [SCORE_W-1:0] r_sc1, r_sc2, r_sc3;
    logic [OPND_W-1:0]  r_ax, r_ay;

    logic [SUM_W-1:0]   r_best;
    logic [IDX_W-1:0]   r_best_idx;
    logic [SCORE_W-1:0] r_best_sc;
    logic               r_found;

    t_out r_res;
    t_out r_out;
    logic r_out_valid;

    logic       in_acc;
    logic       cam_wr;
    logic       issue;
    logic       pipe_busy;
    logic       out_free;
    logic       mark;
    t_slot      wr_slot;
    t_slot      rd_slot;
    logic       rd_taken;
    logic signed [DIFF_W-1:0] dx, dy;
    logic [OPND_W-1:0] mac_a0, mac_b0, mac_a1, mac_b1;
    logic [SUM_W-1:0]  mac_sum;
    logic [SCORE_W-1:0] fused;

    assign o_in_ready = (r_state == ST_IDLE);
    assign in_acc     = i_in_valid && o_in_ready;
    assign cam_wr     = in_acc && (i_in_data.kind == KIND_CAMERA) && (r_count < CNT_MAX);
    assign issue      = (r_state == ST_SCAN) && (r_addr < r_count);
    assign pipe_busy  = r_v0 || r_v1 || r_v2 || r_v3;
    assign out_free   = !r_out_valid || i_out_ready;
    assign mark       = (r_state == ST_SAT) && r_found;

    assign wr_slot.x2 = $signed({i_in_data.box_left[COORD_W-1], i_in_data.box_left, 1'b0}) +
                        $signed({3'b000, i_in_data.box_wide});
    assign wr_slot.y2 = $signed({i_in_data.box_top[COORD_W-1], i_in_data.box_top, 1'b0}) +
                        $signed({3'b000, i_in_data.box_tall});
    assign wr_slot.score = i_in_data.box_score;

    gna_table #(
        .DEPTH (MAX_DETECTIONS),
        .IDX_W (IDX_W)
    ) u_table (
        .i_clk      (i_clk),
        .i_wr_en    (cam_wr),
        .i_wr_addr  (r_count[IDX_W-1:0]),
        .i_wr_data  (wr_slot),
        .i_tk_we    (cam_wr || mark),
        .i_tk_addr  (mark ? r_best_idx : r_count[IDX_W-1:0]),
        .i_tk_val   (mark),
        .i_rd_addr  (r_addr[IDX_W-1:0]),
        .o_rd_data  (rd_slot),
        .o_rd_taken (rd_taken)
    );

    assign dx = DIFF_W'(rd_slot.x2) - DIFF_W'($signed({r_item.obj_px, 1'b0}));
    assign dy = DIFF_W'(rd_slot.y2) - DIFF_W'($signed({r_item.obj_py, 1'b0}));

    always_comb begin
        if (r_state == ST_BLEND) begin
            mac_a0 = OPND_W'(r_lgain);
            mac_b0 = OPND_W'(r_item.obj_score);
            mac_a1 = OPND_W'(r_cgain);
            mac_b1 = OPND_W'(r_best_sc);
        end else begin
            mac_a0 = r_ax;
            mac_b0 = r_ax;
            mac_a1 = r_ay;
            mac_b1 = r_ay;
        end
    end

    gna_mac u_mac (
        .i_clk (i_clk),
        .i_a0  (mac_a0),
        .i_b0  (mac_b0),
        .i_a1  (mac_a1),
        .i_b1  (mac_b1),
        .o_sum (mac_sum)
    );

    assign fused = (|mac_sum[SUM_W-1:GAIN_FRAC+SCORE_W]) ? {SCORE_W{1'b1}}
                 : mac_sum[GAIN_FRAC+SCORE_W-1:GAIN_FRAC];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_acc && (i_in_data.kind == KIND_LIDAR)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!issue && !pipe_busy) begin
                    n_state = r_found ? ST_BLEND : ST_SAT;
                end
            end
            ST_BLEND: n_state = ST_BSUM;
            ST_BSUM:  n_state = ST_SAT;
            ST_SAT:   n_state = ST_DONE;
            ST_DONE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_radius    <= RST_MATCH_RADIUS;
            r_lgain     <= RST_LIDAR_GAIN;
            r_cgain     <= RST_CAMERA_GAIN;
            r_count     <= '0;
            r_addr      <= '0;
            r_v0        <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_thr1      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MATCH_RADIUS: r_radius <= i_cfg_data;
                    CFG_LIDAR_GAIN:   r_lgain  <= i_cfg_data;
                    CFG_CAMERA_GAIN:  r_cgain  <= i_cfg_data;
                    default: ;
                endcase
            end

            if (in_acc) begin
                r_item <= i_in_data;
                r_addr <= '0;
                case (i_in_data.kind)
                    KIND_CLEAR:  r_count <= '0;
                    KIND_CAMERA: begin
                        if (cam_wr) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                    KIND_LIDAR:  r_found <= 1'b0;
                    default: ;
                endcase
            end else if (issue) begin
                r_addr <= r_addr + 1'b1;
            end

            // s0
            r_v0 <= issue;
            r_i0 <= r_addr[IDX_W-1:0];

            // s1: threshold enters on lidar accept, table entries after
            if (in_acc && (i_in_data.kind == KIND_LIDAR)) begin
                r_v1   <= 1'b1;
                r_thr1 <= 1'b1;
                r_ax   <= {1'b0, r_radius, 1'b0};
                r_ay   <= '0;
            end else begin
                r_v1   <= r_v0;
                r_thr1 <= 1'b0;
                r_ax   <= dx[DIFF_W-1] ? OPND_W'(-dx) : OPND_W'(dx);
                r_ay   <= dy[DIFF_W-1] ? OPND_W'(-dy) : OPND_W'(dy);
            end
            r_tk1 <= rd_taken;
            r_i1  <= r_i0;
            r_sc1 <= rd_slot.score;

            // s2, s3 follow the MAC stages
            r_v2   <= r_v1;
            r_thr2 <= r_thr1;
            r_tk2  <= r_tk1;
            r_i2   <= r_i1;
            r_sc2  <= r_sc1;
            r_v3   <= r_v2;
            r_thr3 <= r_thr2;
            r_tk3  <= r_tk2;
            r_i3   <= r_i2;
            r_sc3  <= r_sc2;

            if (r_v3) begin
                if (r_thr3) begin
                    r_best <= mac_sum;
                end else if (!r_tk3 && (mac_sum < r_best)) begin
                    r_best     <= mac_sum;
                    r_best_idx <= r_i3;
                    r_best_sc  <= r_sc3;
                    r_found    <= 1'b1;
                end
            end

            if (r_state == ST_SAT) begin
                r_res.matched     <= r_found;
                r_res.match_slot  <= r_found ? SLOT_OUT_W'(r_best_idx) : '0;
                r_res.fused_score <= r_found ? fused : r_item.obj_score;
            end

            if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                r_out       <= r_res;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_unmatched_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.matched) |-> (o_out_data.match_slot == '0))
        else $error("unmatched result carries a nonzero slot");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_MAX)
        else $error("detection count beyond capacity");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.kind == KIND_CLEAR)) |=> (r_count == '0))
        else $error("clear beat left entries in the table");

    a_scan_no_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2 || r_v3) |-> !o_in_ready)
        else $error("input ready while a scan is in flight");

endmodule
